// File: design/fsfp_pkg.sv
// Shared types and constants for the flow sensor frame parser.
// No dependencies; imported by fsfp_frame, fsfp_out and the parser core.
package fsfp_pkg;

   localparam int MAX_FRAME = 64;
   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int WORD_N = 4;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
   localparam logic [CNT_W-1:0] STAGE_FIRST = CNT_W'(3);
   localparam logic [CNT_W-1:0] STAGE_END = CNT_W'(19);

   localparam logic [7:0] MARKER = 8'hfd;
   localparam logic [7:0] TYPE_ALL = 8'hf1;
   localparam logic [7:0] TYPE_FLOW = 8'hf2;
   localparam logic [7:0] TYPE_HEIGHT = 8'hf3;
   localparam logic [7:0] MIN_LENGTH = 8'd3;

   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_MARKER = 2'd1,
      ST_LENGTH = 2'd2,
      ST_TYPE   = 2'd3
   } status_type;

   typedef logic [WORD_N-1:0][31:0] words_type;

   // End-of-frame summary from the frame accumulator to the result stage
   typedef struct packed {
      logic       done;
      status_type status;
      logic [7:0] frame_type;
      words_type  words;
   } frame_sum_type;

endpackage

// File: design/fsfp_req_if.sv
// Byte channel into the parser: one received byte per word.
// Depends on nothing.
interface fsfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

// File: design/fsfp_rsp_if.sv
// Result channel out of the parser: status and held values per frame.
// Depends on nothing.
interface fsfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] height_bits;
   logic [31:0] speed_z_bits;
   logic [31:0] flow_x_bits;
   logic [31:0] flow_y_bits;
   logic [31:0] flow_time;
   logic [31:0] height_time;
   logic        flow_updated;
   logic        height_updated;

   modport source (output valid, output status, output height_bits, output speed_z_bits,
                   output flow_x_bits, output flow_y_bits, output flow_time,
                   output height_time, output flow_updated, output height_updated,
                   input ready);
   modport sink (input valid, input status, input height_bits, input speed_z_bits,
                 input flow_x_bits, input flow_y_bits, input flow_time,
                 input height_time, input flow_updated, input height_updated,
                 output ready);
endinterface

// File: design/fsfp_frame.sv
// Per-frame accumulator: byte count, checksum, header capture, payload staging.
// Produces the end-of-frame summary. Depends on fsfp_pkg.
module fsfp_frame (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   input  logic                    frame_end,
   output fsfp_pkg::frame_sum_type summary
);
   import fsfp_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       type_ff, type_in;
   logic             marker_ok_ff, marker_ok_in;
   logic             sum_ok_ff, sum_ok_in;
   logic             len_bad_ff, len_bad_in;
   words_type        words_ff, words_in;

   logic [7:0]       count8;
   logic [7:0]       len_m1;
   logic [3:0]       off;
   logic             add_byte;
   logic             len_fail;

   assign count8 = 8'(count_ff);
   assign off = 4'(count_ff - STAGE_FIRST);

   always_comb begin
      count_in = count_ff;
      sum_in = sum_ff;
      len_in = len_ff;
      type_in = type_ff;
      marker_ok_in = marker_ok_ff;
      sum_ok_in = sum_ok_ff;
      len_bad_in = len_bad_ff;
      words_in = words_ff;
      len_m1 = 8'd0;
      add_byte = 1'b0;
      if (count_ff >= CNT_MAX) begin
         // overlong frame: byte dropped
         len_bad_in = 1'b1;
      end else begin
         if (count_ff == CNT_W'(0)) begin
            type_in = rx_byte;
         end
         if (count_ff == CNT_W'(1)) begin
            marker_ok_in = (rx_byte == MARKER);
         end
         if (count_ff == CNT_W'(2)) begin
            len_in = rx_byte;
         end
         len_m1 = len_in - 8'd1;
         add_byte = (count_ff < CNT_W'(2));
         if (count_ff >= CNT_W'(2) && len_in != 8'd0) begin
            if (count8 == len_m1) begin
               sum_ok_in = (sum_ff == rx_byte);
            end else if (count8 < len_m1) begin
               add_byte = 1'b1;
            end
         end
         if (add_byte) begin
            sum_in = sum_ff + rx_byte;
         end
         if (count_ff >= STAGE_FIRST && count_ff < STAGE_END) begin
            words_in[off[3:2]][{off[1:0], 3'b000} +: 8] = rx_byte;
         end
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign len_fail = len_bad_in || (len_in < MIN_LENGTH)
                     || ({1'b0, len_in} > 9'(count_in)) || !sum_ok_in;

   always_comb begin
      summary.done = step && frame_end;
      summary.frame_type = type_in;
      summary.words = words_in;
      if (!marker_ok_in) begin
         summary.status = ST_MARKER;
      end else if (len_fail) begin
         summary.status = ST_LENGTH;
      end else if (type_in == TYPE_ALL || type_in == TYPE_FLOW
                   || type_in == TYPE_HEIGHT) begin
         summary.status = ST_OK;
      end else begin
         summary.status = ST_TYPE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && frame_end)) begin
         count_ff <= '0;
         sum_ff <= '0;
         len_ff <= '0;
         type_ff <= '0;
         marker_ok_ff <= 1'b0;
         sum_ok_ff <= 1'b0;
         len_bad_ff <= 1'b0;
         words_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
         sum_ff <= sum_in;
         len_ff <= len_in;
         type_ff <= type_in;
         marker_ok_ff <= marker_ok_in;
         sum_ok_ff <= sum_ok_in;
         len_bad_ff <= len_bad_in;
         words_ff <= words_in;
      end
   end

endmodule

// File: design/fsfp_out.sv
// Held measurement values and the result register driving the response channel.
// Depends on fsfp_pkg and fsfp_rsp_if.
module fsfp_out (
   input  logic                    clock,
   input  logic                    reset,
   input  fsfp_pkg::frame_sum_type summary,
   fsfp_rsp_if.source              rsp_bus
);
   import fsfp_pkg::*;

   logic [31:0] height_ff, height_in;
   logic [31:0] speed_z_ff, speed_z_in;
   logic [31:0] flow_x_ff, flow_x_in;
   logic [31:0] flow_y_ff, flow_y_in;
   logic [31:0] flow_t_ff, flow_t_in;
   logic [31:0] height_t_ff, height_t_in;
   logic        valid_ff, valid_in;
   status_type  status_ff;
   logic        flow_upd_ff, flow_upd_in;
   logic        height_upd_ff, height_upd_in;

   always_comb begin
      height_in = height_ff;
      speed_z_in = speed_z_ff;
      flow_x_in = flow_x_ff;
      flow_y_in = flow_y_ff;
      flow_t_in = flow_t_ff;
      height_t_in = height_t_ff;
      flow_upd_in = 1'b0;
      height_upd_in = 1'b0;
      if (summary.status == ST_OK) begin
         case (summary.frame_type)
            TYPE_ALL: begin
               height_in = summary.words[0];
               speed_z_in = summary.words[1];
               flow_x_in = summary.words[2];
               flow_y_in = summary.words[3];
               flow_upd_in = 1'b1;
               height_upd_in = 1'b1;
            end
            TYPE_FLOW: begin
               flow_y_in = summary.words[0];
               flow_x_in = summary.words[1] ^ SIGN_BIT;
               flow_t_in = summary.words[2];
               flow_upd_in = 1'b1;
            end
            TYPE_HEIGHT: begin
               height_in = summary.words[0];
               height_t_in = summary.words[1];
               height_upd_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Held values change only when a new result loads, so they drive the payload directly
   assign valid_in = summary.done || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         height_ff <= '0;
         speed_z_ff <= '0;
         flow_x_ff <= '0;
         flow_y_ff <= '0;
         flow_t_ff <= '0;
         height_t_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (summary.done) begin
            height_ff <= height_in;
            speed_z_ff <= speed_z_in;
            flow_x_ff <= flow_x_in;
            flow_y_ff <= flow_y_in;
            flow_t_ff <= flow_t_in;
            height_t_ff <= height_t_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (summary.done) begin
         status_ff <= summary.status;
         flow_upd_ff <= flow_upd_in;
         height_upd_ff <= height_upd_in;
      end
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.height_bits = height_ff;
   assign rsp_bus.speed_z_bits = speed_z_ff;
   assign rsp_bus.flow_x_bits = flow_x_ff;
   assign rsp_bus.flow_y_bits = flow_y_ff;
   assign rsp_bus.flow_time = flow_t_ff;
   assign rsp_bus.height_time = height_t_ff;
   assign rsp_bus.flow_updated = flow_upd_ff;
   assign rsp_bus.height_updated = height_upd_ff;

endmodule

// File: design/flow_sensor_frame_parser_core.sv
// Top level of the flow sensor frame parser: input register, frame accumulator,
// result stage. Depends on fsfp_pkg, fsfp_req_if, fsfp_rsp_if, fsfp_frame, fsfp_out.
//
// Usage:
//   req_bus carries one received byte per word, with frame_end high on the
//   last byte of a burst. rsp_bus gives one word per frame end: the status
//   (accepted, marker wrong, length or checksum error, unknown type), the six
//   held measurement words after this frame's update, and two update flags.
//   Bytes without frame_end produce no response.
//   Throughput: one byte per cycle while no frame end waits on a stalled
//   response. A byte is held in the input register and is folded into the
//   frame state when it advances; a frame end loads the result register at
//   that same edge, so the response comes out of the result register.
//   When rsp_bus stalls, the pending response holds; following bytes keep
//   flowing until the next frame end reaches the input register, which then
//   waits for the result register to drain, and req_bus.ready drops.
//   Reset (synchronous) clears the frame state, the held values and both
//   valid flags.
module flow_sensor_frame_parser_core (
   input logic        clock,
   input logic        reset,
   fsfp_req_if.sink   req_bus,
   fsfp_rsp_if.source rsp_bus
);
   import fsfp_pkg::*;

   logic          in_valid_ff;
   logic [7:0]    byte_ff;
   logic          end_ff;
   logic          slot_free;
   logic          advance;
   frame_sum_type summary;

   assign slot_free = !rsp_bus.valid || rsp_bus.ready;
   assign advance = in_valid_ff && (!end_ff || slot_free);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         byte_ff <= req_bus.rx_byte;
         end_ff <= req_bus.frame_end;
      end
   end

   fsfp_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (byte_ff),
      .frame_end (end_ff),
      .summary   (summary)
   );

   fsfp_out u_out (
      .clock   (clock),
      .reset   (reset),
      .summary (summary),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   a_end_loads_result: assert property (@(posedge clock) disable iff (reset)
      (advance && end_ff) |=> rsp_bus.valid)
      else $error("frame end did not produce a response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(advance && end_ff && rsp_bus.valid && !rsp_bus.ready))
      else $error("pending response overwritten");

   a_ok_updates: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == ST_OK)
         |-> (rsp_bus.flow_updated || rsp_bus.height_updated))
      else $error("accepted frame updated nothing");

   a_bad_no_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != ST_OK)
         |-> (!rsp_bus.flow_updated && !rsp_bus.height_updated))
      else $error("rejected frame flagged an update");
`endif

endmodule

// File: tb/sv/flow_sensor_frame_parser_core_tb.sv
// Testbench for flow_sensor_frame_parser_core: directed and random byte bursts, self-checking.
// Depends on fsfp_pkg, fsfp_req_if, fsfp_rsp_if and the parser core itself.
module flow_sensor_frame_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsfp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_START = 1500;
   localparam int HOLD_CYCLES = 600;
   localparam int RANDOM_BYTES = 1950;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rx_word_type;

   typedef struct {
      status_type  status;
      logic [31:0] height;
      logic [31:0] speed_z;
      logic [31:0] flow_x;
      logic [31:0] flow_y;
      logic [31:0] flow_t;
      logic [31:0] height_t;
      logic        flow_upd;
      logic        height_upd;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fsfp_req_if req_bus();
   fsfp_rsp_if rsp_bus();

   flow_sensor_frame_parser_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rx_word_type      byte_q[$];
   frame_result_type frame_result_q[$];
   int               error_count = 0;
   bit               calm = 1'b0;

   // parser state mirrored in the testbench
   int          p_count;
   logic [7:0]  p_sum;
   logic [7:0]  p_len;
   logic [7:0]  p_type;
   bit          p_marker_ok;
   bit          p_sum_ok;
   bit          p_len_bad;
   logic [31:0] p_words[WORD_N];
   logic [31:0] h_height = '0;
   logic [31:0] h_speed_z = '0;
   logic [31:0] h_flow_x = '0;
   logic [31:0] h_flow_y = '0;
   logic [31:0] h_flow_t = '0;
   logic [31:0] h_height_t = '0;

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic clear_frame_state();
      p_count = 0;
      p_sum = '0;
      p_len = '0;
      p_type = '0;
      p_marker_ok = 1'b0;
      p_sum_ok = 1'b0;
      p_len_bad = 1'b0;
      foreach (p_words[i]) p_words[i] = '0;
   endtask

   // Fold one accepted word into the frame state; a frame end queues the result.
   task automatic fold_byte(input logic [7:0] b, input logic fe);
      bit               add;
      int               off;
      frame_result_type res;
      if (p_count >= MAX_FRAME) begin
         p_len_bad = 1'b1;
      end else begin
         if (p_count == 0) p_type = b;
         if (p_count == 1) p_marker_ok = (b == MARKER);
         if (p_count == 2) p_len = b;
         add = (p_count < 2);
         if (p_count >= 2 && p_len >= 1) begin
            if (p_count == int'(p_len) - 1) p_sum_ok = (p_sum == b);
            else if (p_count < int'(p_len) - 1) add = 1'b1;
         end
         if (add) p_sum = p_sum + b;
         if (p_count >= 3 && p_count < 19) begin
            off = p_count - 3;
            p_words[off >> 2][8 * (off & 3) +: 8] = b;
         end
         p_count++;
      end
      if (fe) begin
         res.flow_upd = 1'b0;
         res.height_upd = 1'b0;
         if (!p_marker_ok) begin
            res.status = ST_MARKER;
         end else if (p_len_bad || p_len < MIN_LENGTH || int'(p_len) > p_count
                      || !p_sum_ok) begin
            res.status = ST_LENGTH;
         end else begin
            res.status = ST_OK;
            case (p_type)
               TYPE_ALL: begin
                  h_height = p_words[0];
                  h_speed_z = p_words[1];
                  h_flow_x = p_words[2];
                  h_flow_y = p_words[3];
                  res.flow_upd = 1'b1;
                  res.height_upd = 1'b1;
               end
               TYPE_FLOW: begin
                  h_flow_y = p_words[0];
                  h_flow_x = p_words[1] ^ SIGN_BIT;
                  h_flow_t = p_words[2];
                  res.flow_upd = 1'b1;
               end
               TYPE_HEIGHT: begin
                  h_height = p_words[0];
                  h_height_t = p_words[1];
                  res.height_upd = 1'b1;
               end
               default: res.status = ST_TYPE;
            endcase
         end
         res.height = h_height;
         res.speed_z = h_speed_z;
         res.flow_x = h_flow_x;
         res.flow_y = h_flow_y;
         res.flow_t = h_flow_t;
         res.height_t = h_height_t;
         frame_result_q.push_back(res);
         clear_frame_state();
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report($sformatf("%s got %h expected %h", name, got, want));
   endtask

   task automatic check_result();
      frame_result_type want;
      if (frame_result_q.size() == 0) begin
         report($sformatf("unexpected result, status %0d", rsp_bus.status));
      end else begin
         want = frame_result_q.pop_front();
         compare_field("status", 32'(rsp_bus.status), 32'(want.status));
         compare_field("height_bits", rsp_bus.height_bits, want.height);
         compare_field("speed_z_bits", rsp_bus.speed_z_bits, want.speed_z);
         compare_field("flow_x_bits", rsp_bus.flow_x_bits, want.flow_x);
         compare_field("flow_y_bits", rsp_bus.flow_y_bits, want.flow_y);
         compare_field("flow_time", rsp_bus.flow_time, want.flow_t);
         compare_field("height_time", rsp_bus.height_time, want.height_t);
         compare_field("flow_updated", 32'(rsp_bus.flow_updated), 32'(want.flow_upd));
         compare_field("height_updated", 32'(rsp_bus.height_updated),
                       32'(want.height_upd));
      end
   endtask

   // Queue one burst: checksum goes at flen-1 when it falls inside the burst past the length byte.
   task automatic make_frame(input logic [7:0] ftype, input int flen, input int nbytes,
                             input bit bad_marker, input bit bad_sum);
      logic [7:0]  fb[$];
      logic [7:0]  sum;
      rx_word_type w;
      for (int i = 0; i < nbytes; i++) fb.push_back(rand_byte());
      fb[0] = ftype;
      if (nbytes > 1) begin
         fb[1] = MARKER;
         if (bad_marker) while (fb[1] == MARKER) fb[1] = rand_byte();
      end
      if (nbytes > 2) fb[2] = flen[7:0];
      if (flen >= 4 && flen <= nbytes) begin
         sum = '0;
         for (int i = 0; i < flen - 1; i++) sum = sum + fb[i];
         if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
         fb[flen-1] = sum;
      end
      foreach (fb[i]) begin
         w.data = fb[i];
         w.last = (i == nbytes - 1);
         byte_q.push_back(w);
      end
   endtask

   function automatic logic [7:0] good_type();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return TYPE_ALL;
      if (r < 6) return TYPE_FLOW;
      if (r < 9) return TYPE_HEIGHT;
      return rand_byte();
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) calm <= !calm;
   end

   // byte driver
   int          send_wait;
   rx_word_type next_word;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_wait = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_wait > 0) begin
            send_wait--;
            req_bus.valid <= 1'b0;
         end else if (byte_q.size() != 0) begin
            next_word = byte_q.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.rx_byte <= next_word.data;
            req_bus.frame_end <= next_word.last;
            send_wait = pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off to back the parser up
   int sink_cycle = 0;
   int sink_wait = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         sink_cycle++;
         if (sink_cycle == HOLD_START) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (sink_wait > 0) begin
            sink_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            sink_wait = pick_gap();
         end
      end
   end

   // monitor: check results, then predict from accepted bytes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) check_result();
         if (req_bus.valid && req_bus.ready) fold_byte(req_bus.rx_byte, req_bus.frame_end);
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("flow_sensor_frame_parser_core_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      int target;
      int r;
      int flen;
      int nbytes;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      req_bus.frame_end = 1'b0;
      rsp_bus.ready = 1'b0;
      clear_frame_state();

      // directed bursts
      make_frame(TYPE_ALL, 0, 1, 0, 0);            // too short for a marker
      make_frame(TYPE_FLOW, 0, 2, 0, 0);           // marker only, no length
      make_frame(TYPE_HEIGHT, 7, 7, 0, 0);
      make_frame(TYPE_FLOW, 8, 8, 0, 0);
      make_frame(TYPE_ALL, 4, 4, 0, 0);            // payload mostly past the end
      make_frame(TYPE_ALL, 5, 5, 1, 0);
      make_frame(TYPE_ALL, 5, 5, 0, 1);
      make_frame(TYPE_HEIGHT, 2, 4, 0, 0);         // length below minimum
      make_frame(8'h06, 3, 3, 0, 0);               // length byte doubles as checksum
      make_frame(TYPE_FLOW, 10, 5, 0, 0);          // truncated
      make_frame(8'h00, 5, 5, 0, 0);               // unknown type
      make_frame(TYPE_HEIGHT, 5, 8, 0, 0);         // trailing bytes past length
      make_frame(TYPE_ALL, 19, 19, 0, 0);

      target = byte_q.size() + RANDOM_BYTES;
      while (byte_q.size() < target) begin
         r = $urandom_range(0, 99);
         flen = ($urandom_range(0, 9) == 0) ? $urandom_range(24, MAX_FRAME)
                                            : $urandom_range(4, 23);
         if (r < 70) begin
            nbytes = ($urandom_range(0, 7) == 0) ? flen + $urandom_range(1, 4) : flen;
            make_frame(good_type(), flen, nbytes, 0, 0);
         end else if (r < 76) begin
            make_frame(good_type(), flen, flen, 1, 0);
         end else if (r < 82) begin
            make_frame(good_type(), flen, flen, 0, 1);
         end else if (r < 87) begin
            flen = $urandom_range(5, 255);
            make_frame(good_type(), flen, $urandom_range(3, (flen > 30) ? 30 : flen - 1),
                       0, 0);
         end else if (r < 91) begin
            make_frame(good_type(), $urandom_range(0, 3), $urandom_range(3, 8), 0, 0);
         end else if (r < 94) begin
            make_frame(good_type(), flen, $urandom_range(MAX_FRAME + 1, MAX_FRAME + 8), 0, 0);
         end else begin
            make_frame(rand_byte(), $urandom_range(0, 255), $urandom_range(1, 6),
                       $urandom_range(0, 1), 0);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (byte_q.size() != 0 || req_bus.valid) @(posedge clock);
      while (frame_result_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (frame_result_q.size() != 0)
         report($sformatf("%0d results never arrived", frame_result_q.size()));

      if (error_count == 0) begin
         $display("flow_sensor_frame_parser_core_tb: clean");
      end else begin
         $display("flow_sensor_frame_parser_core_tb: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/fsfp_pkg.sv
design/fsfp_req_if.sv
design/fsfp_rsp_if.sv
design/fsfp_frame.sv
design/fsfp_out.sv
design/flow_sensor_frame_parser_core.sv
tb/sv/flow_sensor_frame_parser_core_tb.sv
